>>> rtl/etf_pkg.sv
// Shared types, constants and microcode program of the escape-time fractal pixel core.
package etf_pkg;

    localparam int MAX_DEGREE_DEF = 8;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int PC_W           = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic        in_set;
        logic        edge_res;
    } t_pix_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_STEP     = 3'd0,
        CFG_ORIGIN_RE      = 3'd1,
        CFG_ORIGIN_IM      = 3'd2,
        CFG_MAX_ITER       = 3'd3,
        CFG_DEGREE         = 3'd4,
        CFG_CONJUGATE_MODE = 3'd5,
        CFG_ESCAPE_LIMIT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [30:0] pixel_step;
        logic [31:0] origin_re;
        logic [31:0] origin_im;
        logic [15:0] max_iter;
        logic [3:0]  degree;
        logic        conjugate_mode;
        logic [30:0] escape_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pixel_step:     31'd34517,
        origin_re:      32'd43077923,
        origin_im:      32'd18639486,
        max_iter:       16'd100,
        degree:         4'd2,
        conjugate_mode: 1'b0,
        escape_limit:   31'd67108864
    };

    typedef enum logic [2:0] {
        OP_MULC = 3'd0,
        OP_SETC = 3'd1,
        OP_MULZ = 3'd2,
        OP_ACCP = 3'd3,
        OP_ADDZ = 3'd4,
        OP_MEMB = 3'd5,
        OP_FIN  = 3'd6,
        OP_IDLE = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        CND_NONE     = 3'd0,
        CND_NO_IN    = 3'd1,
        CND_C_END    = 3'd2,
        CND_P_SKIP   = 3'd3,
        CND_P_MORE   = 3'd4,
        CND_I_MORE   = 3'd5,
        CND_OUT_BUSY = 3'd6
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic c_end;
        logic p_skip;
        logic p_more;
        logic i_more;
        logic out_busy;
    } t_dp_flags;

    localparam logic [PC_W-1:0] PC_MULC = 3'd0;
    localparam logic [PC_W-1:0] PC_SETC = 3'd1;
    localparam logic [PC_W-1:0] PC_MULZ = 3'd2;
    localparam logic [PC_W-1:0] PC_ACCP = 3'd3;
    localparam logic [PC_W-1:0] PC_ADDZ = 3'd4;
    localparam logic [PC_W-1:0] PC_MEMB = 3'd5;
    localparam logic [PC_W-1:0] PC_FIN  = 3'd6;
    localparam logic [PC_W-1:0] PC_IDLE = 3'd7;

    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_IDLE, cond: CND_NO_IN, target: PC_IDLE};
        unique case (pc)
            PC_MULC: w = '{op: OP_MULC, cond: CND_NONE,     target: PC_MULC};
            PC_SETC: w = '{op: OP_SETC, cond: CND_C_END,    target: PC_MEMB};
            PC_MULZ: w = '{op: OP_MULZ, cond: CND_P_SKIP,   target: PC_ADDZ};
            PC_ACCP: w = '{op: OP_ACCP, cond: CND_P_MORE,   target: PC_MULZ};
            PC_ADDZ: w = '{op: OP_ADDZ, cond: CND_I_MORE,   target: PC_MULZ};
            PC_MEMB: w = '{op: OP_MEMB, cond: CND_NONE,     target: PC_MEMB};
            PC_FIN:  w = '{op: OP_FIN,  cond: CND_OUT_BUSY, target: PC_FIN};
            default: w = '{op: OP_IDLE, cond: CND_NO_IN,    target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/etf_cfg.sv
// Configuration register file with write port.
module etf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [etf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output etf_pkg::t_cfg                 o_cfg
);
    import etf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PIXEL_STEP:     r_cfg.pixel_step     <= i_cfg_wdata[30:0];
                CFG_ORIGIN_RE:      r_cfg.origin_re      <= i_cfg_wdata;
                CFG_ORIGIN_IM:      r_cfg.origin_im      <= i_cfg_wdata;
                CFG_MAX_ITER:       r_cfg.max_iter       <= i_cfg_wdata[15:0];
                CFG_DEGREE:         r_cfg.degree         <= i_cfg_wdata[3:0];
                CFG_CONJUGATE_MODE: r_cfg.conjugate_mode <= i_cfg_wdata[0];
                CFG_ESCAPE_LIMIT:   r_cfg.escape_limit   <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/etf_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module etf_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  etf_pkg::t_dp_flags i_flags,
    output etf_pkg::t_op       o_op
);
    import etf_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            take;

    assign uw = uc_rom(r_pc);

    always_comb begin
        unique case (uw.cond)
            CND_NONE:     take = 1'b0;
            CND_NO_IN:    take = !i_valid;
            CND_C_END:    take = i_flags.c_end;
            CND_P_SKIP:   take = i_flags.p_skip;
            CND_P_MORE:   take = i_flags.p_more;
            CND_I_MORE:   take = i_flags.i_more;
            CND_OUT_BUSY: take = i_flags.out_busy;
            default:      take = 1'b0;
        endcase
        n_pc = take ? uw.target : PC_W'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = uw.op;

endmodule

>>> rtl/etf_dp.sv
// Fixed-point datapath: coordinate mapping, complex multiply, iterate update and result register.
module etf_dp #(
    parameter int MAX_DEGREE = etf_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etf_pkg::t_op       i_op,
    input  etf_pkg::t_cfg      i_cfg,
    input  etf_pkg::t_pix_in   i_data,
    output etf_pkg::t_dp_flags o_flags,
    output logic               o_valid,
    input  logic               i_stall,
    output etf_pkg::t_pix_out  o_data
);
    import etf_pkg::*;

    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int CW = (DW > 4) ? DW : 4;
    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] FX_LIM = 64'sd2147483647;

    function automatic logic fx_fits(input logic signed [63:0] v);
        return (v <= FX_LIM) && (v >= -FX_LIM);
    endfunction

    logic [11:0]        r_col;
    logic [11:0]        r_row;
    logic signed [31:0] r_cr, r_ci, r_zr, r_zi, r_pr, r_pi;
    logic signed [63:0] r_m0, r_m1, r_m2, r_m3;
    logic [DW-1:0]      r_n;
    logic [15:0]        r_k;
    logic               r_esc;
    logic               r_prev;
    logic               r_mem;
    logic               r_edge;
    logic               r_o_valid;
    t_pix_out           r_o_data;

    logic [CW-1:0]      deg_w;
    logic [DW-1:0]      d_eff;
    logic [DW-1:0]      n_inc;
    logic [16:0]        k_inc;
    logic               is_mulc;
    logic signed [31:0] a0, b0, a1, b1;
    logic signed [63:0] p0, p1, p2, p3;
    logic signed [63:0] cr_full, ci_full, re_full, im_full;
    logic signed [31:0] pi_c;
    logic signed [32:0] zr_new, zi_new, lim;
    logic               c_fit, acc_fit, box_ok, out_free;

    assign deg_w = CW'(i_cfg.degree);
    assign d_eff = (deg_w > CW'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(deg_w);

    assign is_mulc = (i_op == OP_MULC);
    assign a0 = is_mulc ? $signed({20'd0, r_col}) : r_pr;
    assign b0 = is_mulc ? $signed({1'b0, i_cfg.pixel_step}) : r_zr;
    assign a1 = is_mulc ? $signed({20'd0, r_row}) : r_pi;
    assign b1 = is_mulc ? $signed({1'b0, i_cfg.pixel_step}) : r_zi;
    assign p0 = a0 * b0;
    assign p1 = a1 * b1;
    assign p2 = r_pr * r_zi;
    assign p3 = r_pi * r_zr;

    assign cr_full = r_m0 - 64'($signed(i_cfg.origin_re));
    assign ci_full = r_m1 - 64'($signed(i_cfg.origin_im));
    assign c_fit   = fx_fits(cr_full) && fx_fits(ci_full);

    assign re_full = (r_m0 - r_m1) >>> FRAC_BITS;
    assign im_full = (r_m2 + r_m3) >>> FRAC_BITS;
    assign acc_fit = fx_fits(re_full) && fx_fits(im_full);
    assign n_inc   = DW'(r_n + 1'b1);

    assign pi_c   = i_cfg.conjugate_mode ? -r_pi : r_pi;
    assign zr_new = 33'(r_pr) + 33'(r_cr);
    assign zi_new = 33'(pi_c) + 33'(r_ci);
    assign lim    = $signed({2'b00, i_cfg.escape_limit});
    assign box_ok = (zr_new < lim) && (zr_new > -lim) && (zi_new < lim) && (zi_new > -lim);
    assign k_inc  = {1'b0, r_k} + 17'd1;

    assign out_free = !r_o_valid || !i_stall;

    assign o_flags.c_end    = (i_cfg.max_iter == 16'd0) || !c_fit;
    assign o_flags.p_skip   = (r_n >= d_eff);
    assign o_flags.p_more   = acc_fit && (n_inc < d_eff);
    assign o_flags.i_more   = !r_esc && box_ok && (k_inc != {1'b0, i_cfg.max_iter});
    assign o_flags.out_busy = !out_free;

    always_ff @(posedge i_clk) begin
        unique case (i_op) inside
            OP_IDLE: begin
                r_col <= i_data.column;
                r_row <= i_data.row;
            end
            OP_MULC, OP_MULZ: begin
                r_m0 <= p0;
                r_m1 <= p1;
                r_m2 <= p2;
                r_m3 <= p3;
            end
            OP_SETC: begin
                r_cr  <= cr_full[31:0];
                r_ci  <= ci_full[31:0];
                r_esc <= (i_cfg.max_iter != 16'd0) && !c_fit;
                r_zr  <= '0;
                r_zi  <= '0;
                r_k   <= '0;
                r_pi  <= '0;
                if (d_eff == '0) begin
                    r_pr <= FX_ONE;
                    r_n  <= '0;
                end else begin
                    r_pr <= '0;
                    r_n  <= DW'(1);
                end
            end
            OP_ACCP: begin
                r_pr <= re_full[31:0];
                r_pi <= im_full[31:0];
                r_n  <= n_inc;
                if (!acc_fit) begin
                    r_esc <= 1'b1;
                end
            end
            OP_ADDZ: begin
                r_zr <= zr_new[31:0];
                r_zi <= zi_new[31:0];
                r_k  <= k_inc[15:0];
                if (!box_ok) begin
                    r_esc <= 1'b1;
                end
                if (d_eff == '0) begin
                    r_pr <= FX_ONE;
                    r_pi <= '0;
                    r_n  <= '0;
                end else begin
                    r_pr <= zr_new[31:0];
                    r_pi <= zi_new[31:0];
                    r_n  <= DW'(1);
                end
            end
            OP_MEMB: begin
                r_mem  <= !r_esc;
                r_edge <= !r_esc ^ ((r_col == 12'd0) ? 1'b0 : r_prev);
            end
            OP_FIN: begin
                if (out_free) begin
                    r_o_data <= '{pixel_column: r_col, in_set: r_mem, edge_res: r_edge};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_op == OP_MEMB) begin
                r_prev <= !r_esc;
            end
            if (i_op == OP_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

>>> rtl/escape_time_fractal_pixel_core.sv
// Escape-time fractal pixel core top level: config registers, microcode sequencer and datapath.
// Each iteration repeats the four-multiplier complex product and its floor step until
// the power of z reaches the degree, then adds c; an early escape ends the pixel sooner.
// One pixel is worked on at a time. A new input beat is taken while the previous result
// still waits in o_data.
// Reset (synchronous, active low) loads register defaults, clears the edge history and
// output valid, and leaves the core ready for input on the next cycle.
module escape_time_fractal_pixel_core #(
    parameter int MAX_DEGREE = etf_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  etf_pkg::t_pix_in               i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output etf_pkg::t_pix_out              o_data,
    input  logic                           i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [etf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import etf_pkg::*;

    t_cfg      cfg;
    t_op       op;
    t_dp_flags flags;

    etf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    etf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_flags (flags),
        .o_op    (op)
    );

    etf_dp #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_cfg   (cfg),
        .i_data  (i_data),
        .o_flags (flags),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    assign o_stall = (op != OP_IDLE);

endmodule

>>> rtl/etf_checker.sv
// Port-level assertion checker for the escape-time fractal pixel core, with its bind.
module etf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input etf_pkg::t_pix_out o_data
);

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not clean after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again while pixel in flight");

    a_idle_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !i_valid |=> !o_stall)
        else $error("core left idle without an input beat");

    a_row_start_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.pixel_column == 12'd0) |-> (o_data.edge_res == o_data.in_set))
        else $error("row start edge flag does not match membership");

endmodule

bind escape_time_fractal_pixel_core etf_checker u_etf_checker (.*);
